// ----- design/cst_pkg.sv -----
// ============================================================================
// cst_pkg
// Shared types and constants for the C subset tokenizer.
// ============================================================================
package cst_pkg;

    localparam int DEF_MAX_SOURCE_BYTES = 65536;
    localparam int DEF_MAX_NAME_LEN     = 63;
    localparam int QUEUE_DEPTH          = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef enum logic [3:0] {
        TK_INT    = 4'd0,
        TK_IDENT  = 4'd1,
        TK_LPAREN = 4'd2,
        TK_RPAREN = 4'd3,
        TK_LBRACE = 4'd4,
        TK_RBRACE = 4'd5,
        TK_RETURN = 4'd6,
        TK_NUMBER = 4'd7,
        TK_PLUS   = 4'd8,
        TK_MINUS  = 4'd9,
        TK_STAR   = 4'd10,
        TK_SEMI   = 4'd11,
        TK_EOF    = 4'd12,
        TK_ERROR  = 4'd13
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [15:0] start;
        logic [5:0]  len;
    } token_t;

    // one accepted item's output: one token in a, or two in a then b
    typedef struct packed {
        logic   two;
        token_t a;
        token_t b;
    } rec_t;

    typedef struct packed {
        logic valid;
        rec_t rec;
    } rec_bus_t;

endpackage

// ----- design/cst_front.sv -----
// ============================================================================
// cst_front
// Scanner: takes source bytes, keeps token state, builds token records.
// ============================================================================
module cst_front
    import cst_pkg::*;
#(
    parameter int MAX_SOURCE_BYTES = DEF_MAX_SOURCE_BYTES,
    parameter int MAX_NAME_LEN     = DEF_MAX_NAME_LEN
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       end_of_source,
    output rec_bus_t   push
);

    localparam int OFS_W = $clog2(MAX_SOURCE_BYTES);
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MAX_SOURCE_BYTES - 1);
    localparam logic [5:0] LEN_CAP = (MAX_NAME_LEN < 63) ? 6'(MAX_NAME_LEN) : 6'd63;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } mode_t;

    mode_t            mode_reg,  mode_next;
    logic [31:0]      acc_reg,   acc_next;
    logic [15:0]      pstart_reg, pstart_next;
    logic [5:0]       plen_reg,  plen_next;
    logic [1:0]       cand_reg,  cand_next;
    logic [OFS_W-1:0] ofs_reg,   ofs_next;
    logic             err_reg,   err_next;

    logic   is_end, is_ws, is_letter, is_digit;
    logic   flush_valid, use_flush, sec_valid;
    token_t flush_tok, sec_tok;
    logic [5:0] plen_grow;
    logic [31:0] digit_val;

    function automatic logic [7:0] kw_int_at(input logic [5:0] p);
        case (p)
            6'd0:    kw_int_at = 8'h69;
            6'd1:    kw_int_at = 8'h6E;
            6'd2:    kw_int_at = 8'h74;
            default: kw_int_at = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_return_at(input logic [5:0] p);
        case (p)
            6'd0:    kw_return_at = 8'h72;
            6'd1:    kw_return_at = 8'h65;
            6'd2:    kw_return_at = 8'h74;
            6'd3:    kw_return_at = 8'h75;
            6'd4:    kw_return_at = 8'h72;
            6'd5:    kw_return_at = 8'h6E;
            default: kw_return_at = 8'h00;
        endcase
    endfunction

    function automatic kind_t single_kind(input logic [7:0] c);
        case (c)
            8'h28:   single_kind = TK_LPAREN;
            8'h29:   single_kind = TK_RPAREN;
            8'h7B:   single_kind = TK_LBRACE;
            8'h7D:   single_kind = TK_RBRACE;
            8'h2B:   single_kind = TK_PLUS;
            8'h2D:   single_kind = TK_MINUS;
            8'h2A:   single_kind = TK_STAR;
            8'h3B:   single_kind = TK_SEMI;
            default: single_kind = TK_ERROR;
        endcase
    endfunction

    always_comb
    begin
        is_end    = end_of_source || (char_in == 8'h00);
        is_ws     = (char_in inside {[8'd9:8'd13], 8'd32});
        is_letter = (char_in inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER});
        is_digit  = (char_in inside {[8'h30:8'h39]});
        digit_val = {24'd0, char_in - CH_ZERO};
        plen_grow = (plen_reg < LEN_CAP) ? plen_reg + 6'd1 : plen_reg;

        flush_valid     = (mode_reg != MODE_IDLE);
        flush_tok.value = (mode_reg == MODE_NUMBER) ? acc_reg : 32'd0;
        flush_tok.start = pstart_reg;
        flush_tok.len   = plen_reg;
        if (mode_reg == MODE_NUMBER)
        begin
            flush_tok.kind = TK_NUMBER;
        end
        else if (cand_reg[0] && plen_reg == 6'd3)
        begin
            flush_tok.kind = TK_INT;
        end
        else if (cand_reg[1] && plen_reg == 6'd6)
        begin
            flush_tok.kind = TK_RETURN;
        end
        else
        begin
            flush_tok.kind = TK_IDENT;
        end

        sec_valid     = 1'b0;
        sec_tok.kind  = single_kind(char_in);
        sec_tok.value = 32'd0;
        sec_tok.start = 16'(ofs_reg);
        sec_tok.len   = 6'd1;
        use_flush     = 1'b0;

        mode_next   = mode_reg;
        acc_next    = acc_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        cand_next   = cand_reg;
        err_next    = err_reg;
        ofs_next    = (ofs_reg == OFS_LAST) ? '0 : ofs_reg + 1'b1;

        if (is_end)
        begin
            use_flush    = flush_valid;
            sec_valid    = 1'b1;
            sec_tok.kind = TK_EOF;
            sec_tok.len  = 6'd0;
            mode_next    = MODE_IDLE;
            acc_next     = 32'd0;
            pstart_next  = 16'd0;
            plen_next    = 6'd0;
            cand_next    = 2'b11;
            err_next     = 1'b0;
            ofs_next     = '0;
        end
        else if (err_reg)
        begin
            mode_next = mode_reg;
        end
        else if (mode_reg == MODE_IDENT && (is_letter || is_digit))
        begin
            cand_next[0] = cand_reg[0] && (kw_int_at(plen_reg) == char_in);
            cand_next[1] = cand_reg[1] && (kw_return_at(plen_reg) == char_in);
            plen_next    = plen_grow;
        end
        else if (mode_reg == MODE_NUMBER && is_digit)
        begin
            acc_next  = (acc_reg << 3) + (acc_reg << 1) + digit_val;
            plen_next = plen_grow;
        end
        else
        begin
            use_flush = flush_valid;
            mode_next = MODE_IDLE;
            acc_next  = 32'd0;
            plen_next = 6'd0;
            cand_next = 2'b11;
            if (is_ws)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_letter)
            begin
                mode_next    = MODE_IDENT;
                pstart_next  = 16'(ofs_reg);
                plen_next    = 6'd1;
                cand_next[0] = (char_in == kw_int_at(6'd0));
                cand_next[1] = (char_in == kw_return_at(6'd0));
            end
            else if (is_digit)
            begin
                mode_next   = MODE_NUMBER;
                pstart_next = 16'(ofs_reg);
                plen_next   = 6'd1;
                acc_next    = digit_val;
            end
            else
            begin
                sec_valid = 1'b1;
                if (sec_tok.kind == TK_ERROR)
                begin
                    err_next = 1'b1;
                end
            end
        end

        push.valid   = accept && (use_flush || sec_valid);
        push.rec.two = use_flush && sec_valid;
        push.rec.a   = use_flush ? flush_tok : sec_tok;
        push.rec.b   = sec_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= 32'd0;
            pstart_reg <= 16'd0;
            plen_reg   <= 6'd0;
            cand_reg   <= 2'b11;
            ofs_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            cand_reg   <= cand_next;
            ofs_reg    <= ofs_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ----- design/cst_queue.sv -----
// ============================================================================
// cst_queue
// Short record queue between scanner and output stage.
// ============================================================================
module cst_queue
    import cst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rec_bus_t push,
    input  logic     pop,
    output rec_bus_t head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    rec_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0]  level_reg;
    logic              do_push, do_pop;

    assign do_pop     = pop && (level_reg != '0);
    assign do_push    = push.valid;
    assign head.valid = (level_reg != '0);
    assign head.rec   = mem[rd_ptr_reg];
    assign level      = level_reg;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/cst_back.sv -----
// ============================================================================
// cst_back
// Output stage: splits records into single tokens on the output stream.
// ============================================================================
module cst_back
    import cst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rec_bus_t    head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic        m_tlast
);

    logic   out_valid_reg, out_last_reg, pend_valid_reg;
    token_t out_tok_reg, pend_tok_reg;
    logic   load;

    assign load     = !out_valid_reg || m_tready;
    assign pop      = load && !pend_valid_reg && head.valid;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_tok_reg.len, out_tok_reg.start, out_tok_reg.value,
                       out_tok_reg.kind};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_valid_reg)
            begin
                out_tok_reg <= pend_tok_reg;
            end
            else
            begin
                out_tok_reg  <= head.rec.a;
                pend_tok_reg <= head.rec.b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_last_reg   <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= head.valid;
                out_last_reg   <= !head.rec.two;
                pend_valid_reg <= head.valid && head.rec.two;
            end
        end
    end

endmodule

// ----- design/c_subset_tokenizer_top.sv -----
// ============================================================================
// c_subset_tokenizer_top
// Byte-stream tokenizer for a small C subset, scanner and output decoupled.
//
// channel  dir  tdata                                       tlast
// s_*      in   [7:0] char_in                               end_of_source
// m_*      out  [3:0] kind [35:4] value [51:36] start       last_of_run
//               [57:52] length
//
// One byte per cycle enters the scanner while s_tready is high; a byte that
// yields one token sustains one item per cycle, and a byte yielding two tokens
// sends them one after the other. The output register drains one token per
// cycle; a four-record queue absorbs output stalls, and s_tready drops only when that queue is full.
// Reset is asynchronous and clears all scanner state; no clearing pass.
// ============================================================================
module c_subset_tokenizer_top
    import cst_pkg::*;
#(
    parameter int MAX_SOURCE_BYTES = DEF_MAX_SOURCE_BYTES,
    parameter int MAX_NAME_LEN     = DEF_MAX_NAME_LEN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // kind, number_value, token_start, token_length
    output logic        m_tlast    // last_of_run
);

    rec_bus_t push, head;
    logic     pop, accept;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] level;

    assign s_tready = (level != ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign accept   = s_tvalid && s_tready;

    cst_front #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES),
        .MAX_NAME_LEN     (MAX_NAME_LEN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_in       (s_tdata),
        .end_of_source (s_tlast),
        .push          (push)
    );

    cst_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    cst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
        else $error("queue level above depth");

    a_push_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> accept)
        else $error("record pushed without an accepted item");

    a_end_gives_eof: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tlast || s_tdata == 8'h00)) |->
            (push.valid && push.rec.b.kind == TK_EOF))
        else $error("end item did not queue an eof token");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C subset tokenizer.
// Source bytes go in through a queue-fed driver. The token stream is checked
// item by item against a scanner model kept inside the bench. The run covers
// directed keywords and punctuation, a name longer than the length cap,
// and random sources. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
    import cst_pkg::*;

    localparam int RAND_ITEMS = 750;
    localparam int TAIL_ITEMS = 100;
    localparam int STALL_LIMIT = 1000;
    localparam int LEN_CAP = (DEF_MAX_NAME_LEN < 63) ? DEF_MAX_NAME_LEN : 63;
    localparam logic [23:0] KW_INT = "int";
    localparam logic [47:0] KW_RETURN = "return";
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NAME, SCAN_NUM} scan_t;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        logic       hold;   // wait for all tokens to drain before sending
    } src_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] value;
        logic [15:0] start;
        logic [5:0]  len;
        logic        last;
    } token_rec_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic        m_tlast;

    src_item_t   src_bytes[$];
    token_rec_t  tokens_due[$];
    int          n_total;
    int          n_taken;
    int          n_errors;
    int          src_gap;
    int          snk_gap;
    int          quiet_cycles;
    logic        s_took;

    // scanner model state
    scan_t       mode;
    logic [31:0] acc;
    logic [15:0] run_start;
    logic [5:0]  run_len;
    logic [1:0]  kw_live;
    int          src_pos;
    logic        err_seen;

    c_subset_tokenizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] char_in
        .s_tlast  (s_tlast),   // end_of_source
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [3:0] kind [35:4] value [51:36] start [57:52] length
        .m_tlast  (m_tlast)    // last_of_run
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- scanner model ----------------
    task automatic push_token(input kind_t k, input logic [31:0] v, input logic [15:0] st,
                              input logic [5:0] ln, inout int n);
        token_rec_t t;
        t.kind  = k;
        t.value = v;
        t.start = st;
        t.len   = ln;
        t.last  = 1'b0;
        tokens_due.push_back(t);
        n++;
    endtask

    task automatic flush_pending(inout int n);
        kind_t k;
        if (mode == SCAN_NAME)
        begin
            k = TK_IDENT;
            if (kw_live[0] && run_len == 6'd3)
                k = TK_INT;
            else if (kw_live[1] && run_len == 6'd6)
                k = TK_RETURN;
            push_token(k, 32'd0, run_start, run_len, n);
        end
        else if (mode == SCAN_NUM)
        begin
            push_token(TK_NUMBER, acc, run_start, run_len, n);
        end
        mode    = SCAN_IDLE;
        acc     = 32'd0;
        run_len = 6'd0;
        kw_live = 2'b11;
    endtask

    task automatic name_char(input logic [7:0] ch);
        int p;
        p = int'(run_len);
        if (p >= 3 || KW_INT[8 * (2 - p) +: 8] != ch)
            kw_live[0] = 1'b0;
        if (p >= 6 || KW_RETURN[8 * (5 - p) +: 8] != ch)
            kw_live[1] = 1'b0;
        if (run_len < LEN_CAP)
            run_len++;
    endtask

    function automatic logic is_name_start(input logic [7:0] ch);
        return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z") || ch == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= CH_ZERO && ch <= "9";
    endfunction

    task automatic reset_scanner();
        mode      = SCAN_IDLE;
        acc       = 32'd0;
        run_start = 16'd0;
        run_len   = 6'd0;
        kw_live   = 2'b11;
        src_pos   = 0;
        err_seen  = 1'b0;
    endtask

    task automatic lex_byte(input logic [7:0] ch, input logic eos);
        int    n;
        kind_t k;
        n = 0;
        if (eos || ch == CH_NUL)
        begin
            flush_pending(n);
            push_token(TK_EOF, 32'd0, src_pos[15:0], 6'd0, n);
            reset_scanner();
        end
        else
        begin
            if (!err_seen)
            begin
                if (mode == SCAN_NAME && (is_name_start(ch) || is_digit(ch)))
                begin
                    name_char(ch);
                end
                else if (mode == SCAN_NUM && is_digit(ch))
                begin
                    acc = acc * 32'd10 + {24'd0, ch - CH_ZERO};
                    if (run_len < LEN_CAP)
                        run_len++;
                end
                else
                begin
                    flush_pending(n);
                    if ((ch >= CH_TAB && ch <= CH_CR) || ch == CH_SPACE)
                    begin
                        // whitespace: nothing
                    end
                    else if (is_name_start(ch) || is_digit(ch))
                    begin
                        run_start = src_pos[15:0];
                        run_len   = 6'd0;
                        acc       = 32'd0;
                        kw_live   = 2'b11;
                        if (is_digit(ch))
                        begin
                            mode    = SCAN_NUM;
                            acc     = {24'd0, ch - CH_ZERO};
                            run_len = 6'd1;
                        end
                        else
                        begin
                            mode = SCAN_NAME;
                            name_char(ch);
                        end
                    end
                    else
                    begin
                        case (ch)
                            "(":     k = TK_LPAREN;
                            ")":     k = TK_RPAREN;
                            "{":     k = TK_LBRACE;
                            "}":     k = TK_RBRACE;
                            "+":     k = TK_PLUS;
                            "-":     k = TK_MINUS;
                            "*":     k = TK_STAR;
                            ";":     k = TK_SEMI;
                            default: k = TK_ERROR;
                        endcase
                        push_token(k, 32'd0, src_pos[15:0], 6'd1, n);
                        if (k == TK_ERROR)
                            err_seen = 1'b1;
                    end
                end
            end
            src_pos = (src_pos + 1) % DEF_MAX_SOURCE_BYTES;
        end
        if (n > 0)
            tokens_due[tokens_due.size() - 1].last = 1'b1;
    endtask

    // ---------------- stimulus ----------------
    task automatic put_byte(input logic [7:0] ch, input logic eos, input logic hold);
        src_item_t it;
        it.ch   = ch;
        it.eos  = eos;
        it.hold = hold;
        src_bytes.push_back(it);
        n_total++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i], 1'b0, 1'b0);
    endtask

    // ---------------- source side ----------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || s_took)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (src_bytes.size() == 0 ||
                     (src_bytes[0].hold && tokens_due.size() != 0))
            begin
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata  <= src_bytes[0].ch;
                s_tlast  <= src_bytes[0].eos;
                s_tvalid <= 1'b1;
                void'(src_bytes.pop_front());
                if (src_bytes.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 12);
            end
        end
    end

    // ---------------- sink side ----------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (src_bytes.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0)
                snk_gap = $urandom_range(1, 12);
        end
    end

    // ---------------- monitor, checker, watchdog ----------------
    always @(posedge clk)
    begin
        token_rec_t got;
        token_rec_t want;
        s_took <= s_tvalid && s_tready && rst_n;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                lex_byte(s_tdata, s_tlast);
                n_taken++;
            end
            if (m_tvalid && m_tready)
            begin
                got.kind  = kind_t'(m_tdata[3:0]);
                got.value = m_tdata[35:4];
                got.start = m_tdata[51:36];
                got.len   = m_tdata[57:52];
                got.last  = m_tlast;
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: unexpected token: kind %0d value %0d start %0d len %0d last %0d",
                             $time, got.kind, got.value, got.start, got.len, got.last);
                    n_errors++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: token mismatch: expected kind %0d value %0d start %0d len %0d last %0d",
                                 $time, want.kind, want.value, want.start, want.len, want.last);
                        $display("%0t:                 actual   kind %0d value %0d start %0d len %0d last %0d",
                                 $time, got.kind, got.value, got.start, got.len, got.last);
                        n_errors++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial
    begin
        string alnum;
        string kw_chars;
        string singles;
        string spaces;
        int    rand_base;
        int    n_tok;
        int    pick;
        int    len;

        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        s_took       = 1'b0;
        rst_n        = 1'b0;
        n_total      = 0;
        n_taken      = 0;
        n_errors     = 0;
        src_gap      = 0;
        snk_gap      = 0;
        quiet_cycles = 0;
        reset_scanner();

        alnum    = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
        kw_chars = "intreu_";
        singles  = "(){}+-*;";
        spaces   = " \t\n\v\f\r";

        // directed: keywords, all punctuation, flush on end, error then ignore
        put_text("int(){}return+-*;a1 42");
        put_byte("z", 1'b1, 1'b0);
        put_byte(8'hFF, 1'b0, 1'b0);
        put_byte("q", 1'b0, 1'b0);
        put_byte(CH_NUL, 1'b0, 1'b0);

        // long name past the length cap; sender waits for a full drain first
        put_byte(CH_SPACE, 1'b0, 1'b1);
        for (int i = 0; i < 70; i++)
            put_byte(alnum[i % 63], 1'b0, 1'b0);
        put_text(";7 int");
        put_byte(8'h80, 1'b1, 1'b0);

        // random sources
        rand_base = n_total;
        while (n_total - rand_base < RAND_ITEMS)
        begin
            n_tok = $urandom_range(1, 12);
            for (int t = 0; t < n_tok; t++)
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    put_text("int");
                else if (pick == 1)
                    put_text("return");
                else if (pick <= 4)
                begin
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                       : $urandom_range(1, 7);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 1))
                            put_byte(kw_chars[$urandom_range(0, 6)], 1'b0, 1'b0);
                        else
                            put_byte(alnum[(i == 0) ? $urandom_range(0, 52)
                                                    : $urandom_range(0, 62)], 1'b0, 1'b0);
                    end
                end
                else if (pick <= 7)
                begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
                                                      : $urandom_range(1, 3);
                    for (int i = 0; i < len; i++)
                        put_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0, 1'b0);
                end
                else if (pick <= 13)
                    put_byte(singles[$urandom_range(0, 7)], 1'b0, 1'b0);
                else if (pick == 14)
                    put_byte(8'($urandom_range(1, 255)), 1'b0, 1'b0);
                else
                begin
                    repeat ($urandom_range(1, 4))
                        put_byte(spaces[$urandom_range(0, 5)], 1'b0, 1'b0);
                end
                repeat ($urandom_range(0, 2))
                    put_byte(spaces[$urandom_range(0, 5)], 1'b0, 1'b0);
            end
            if ($urandom_range(0, 1))
                put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            else
                put_byte(CH_NUL, 1'b0, 1'b0);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_taken != n_total || tokens_due.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);

        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
